/* sv/tea_pkg.sv */
// ----------------------------------------------------------------------------
// tea_pkg: shared types, constants and the TEA mixing function
// Holds the block and key types that pass between the cells and the
// output buffer, the configuration register indexes and the round constant.
// ----------------------------------------------------------------------------
package tea_pkg;

  localparam logic [31:0] DELTA = 32'h9e37_79b9;

  localparam int unsigned CFG_IDX_W = 8;

  localparam logic [CFG_IDX_W-1:0] KEY_W0_IDX = 8'd0;
  localparam logic [CFG_IDX_W-1:0] KEY_W1_IDX = 8'd1;
  localparam logic [CFG_IDX_W-1:0] KEY_W2_IDX = 8'd2;
  localparam logic [CFG_IDX_W-1:0] KEY_W3_IDX = 8'd3;

  typedef struct packed {
    logic        func;
    logic [31:0] left;
    logic [31:0] right;
  } tea_blk_t;

  typedef struct packed {
    logic [31:0] w0;
    logic [31:0] w1;
    logic [31:0] w2;
    logic [31:0] w3;
  } tea_key_t;

  // Half-round mix: ((x << 4) + ka) ^ (x + s) ^ ((x >> 5) + kb), all mod 2^32.
  function automatic logic [31:0] mix(input logic [31:0] x, input logic [31:0] s,
                                      input logic [31:0] ka, input logic [31:0] kb);
    logic [31:0] a;
    logic [31:0] b;
    logic [31:0] c;
    a = (x << 4) + ka;
    b = x + s;
    c = (x >> 5) + kb;
    return a ^ b ^ c;
  endfunction

endpackage

/* sv/tea_cell.sv */
// ----------------------------------------------------------------------------
// tea_cell: one half-round of the cipher
// Updates one word of the block with the mixed other word and registers the
// result. The round sum is a constant of the cell's position in the chain.
// ----------------------------------------------------------------------------
module tea_cell #(
  parameter int STEP   = 0,
  parameter int ROUNDS = 32
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  logic              in_valid,
  input  tea_pkg::tea_blk_t in_blk,
  input  tea_pkg::tea_key_t key,
  output logic              out_valid,
  output tea_pkg::tea_blk_t out_blk
);

  localparam int          RND     = STEP / 2;
  localparam logic        ODD     = 1'(STEP % 2);
  localparam logic [31:0] SUM_ENC = 32'(64'(tea_pkg::DELTA) * 64'(RND + 1));
  localparam logic [31:0] SUM_DEC = 32'(64'(tea_pkg::DELTA) * 64'(ROUNDS - RND));

  logic              valid_r;
  tea_pkg::tea_blk_t blk_r;
  tea_pkg::tea_blk_t blk_nxt;

  logic        upd_left;
  logic [31:0] x;
  logic [31:0] ka;
  logic [31:0] kb;
  logic [31:0] s;
  logic [31:0] m;
  logic [31:0] tgt;
  logic [31:0] res;

  // Encryption updates the left word on even steps; decryption runs the
  // halves in reverse and updates the left word on odd steps.
  always_comb begin
    upd_left = (in_blk.func == ODD);
    x        = upd_left ? in_blk.right : in_blk.left;
    ka       = upd_left ? key.w0 : key.w2;
    kb       = upd_left ? key.w1 : key.w3;
    s        = in_blk.func ? SUM_DEC : SUM_ENC;
    m        = tea_pkg::mix(x, s, ka, kb);
    tgt      = upd_left ? in_blk.left : in_blk.right;
    res      = in_blk.func ? (tgt - m) : (tgt + m);
    blk_nxt  = in_blk;
    if (upd_left) begin
      blk_nxt.left = res;
    end else begin
      blk_nxt.right = res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      blk_r <= blk_nxt;
    end
  end

  assign out_valid = valid_r;
  assign out_blk   = blk_r;

endmodule

/* sv/tea_obuf.sv */
// ----------------------------------------------------------------------------
// tea_obuf: output register with a skid entry
// Takes the block leaving the last cell and holds it for the result channel.
// The skid entry catches one block while the result side stalls, and the
// chain halts only while that entry is occupied.
// ----------------------------------------------------------------------------
module tea_obuf (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  tea_pkg::tea_blk_t in_blk,
  output logic              full,
  output logic              out_valid,
  input  logic              out_stall,
  output tea_pkg::tea_blk_t out_blk
);

  logic              out_valid_r;
  tea_pkg::tea_blk_t out_blk_r;
  logic              skid_valid_r;
  tea_pkg::tea_blk_t skid_blk_r;
  logic              arrive;

  // A block leaves the chain only while the chain is moving.
  assign arrive = in_valid && !skid_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (!out_valid_r || !out_stall) begin
      if (skid_valid_r) begin
        out_blk_r    <= skid_blk_r;
        out_valid_r  <= 1'b1;
        skid_valid_r <= 1'b0;
      end else begin
        out_valid_r <= arrive;
        if (arrive) begin
          out_blk_r <= in_blk;
        end
      end
    end else if (arrive) begin
      skid_blk_r   <= in_blk;
      skid_valid_r <= 1'b1;
    end
  end

  assign full      = skid_valid_r;
  assign out_valid = out_valid_r;
  assign out_blk   = out_blk_r;

`ifndef ASSERT_OFF
  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid entry holds a block while the output register is empty");

  a_skid_fill_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !skid_valid_r && in_valid && out_valid_r && out_stall |=> skid_valid_r)
    else $error("block from the chain was not caught by the skid entry");

  a_skid_drains: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r && !out_stall |=> !skid_valid_r && out_valid_r
      && out_blk_r == $past(skid_blk_r))
    else $error("skid entry did not move into the output register");
`endif

endmodule

/* sv/tea_block_cipher.sv */
// ----------------------------------------------------------------------------
// tea_block_cipher: TEA encrypt/decrypt engine, 64-bit block, 128-bit key
// Pipelined cipher built as a chain of half-round cells.
// ----------------------------------------------------------------------------
// The engine accepts one block per clock cycle while the input is not
// stalled and returns one result per block, in order. Each of the 2*ROUNDS
// cells performs one half-round and registers the block, and the output
// register follows the last cell. A stall on the result side is absorbed by
// a one-entry skid buffer; the input stalls only while that entry is
// occupied. The key is held in four 32-bit registers that reset to zero and
// are written through the configuration port; the user must write them only
// while no block is in flight, which the block itself does not enforce;
// writes to indexes beyond three are ignored.
module tea_block_cipher #(
  parameter int ROUNDS = 32
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          in_func,
  input  logic [31:0]                   in_left,
  input  logic [31:0]                   in_right,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [31:0]                   out_left,
  output logic [31:0]                   out_right,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [tea_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]                   cfg_data
);

  localparam int STAGES = 2 * ROUNDS;

  tea_pkg::tea_key_t key_r;
  logic              buf_full;
  logic              en;
  logic              stage_valid [0:STAGES];
  tea_pkg::tea_blk_t stage_blk   [0:STAGES];
  tea_pkg::tea_blk_t res_blk;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        tea_pkg::KEY_W0_IDX: key_r.w0 <= cfg_data;
        tea_pkg::KEY_W1_IDX: key_r.w1 <= cfg_data;
        tea_pkg::KEY_W2_IDX: key_r.w2 <= cfg_data;
        tea_pkg::KEY_W3_IDX: key_r.w3 <= cfg_data;
        default: ;
      endcase
    end
  end

  // The whole chain moves together and halts only while the skid entry is full.
  assign en       = !buf_full;
  assign in_stall = buf_full;

  assign stage_valid[0]     = in_valid;
  assign stage_blk[0].func  = in_func;
  assign stage_blk[0].left  = in_left;
  assign stage_blk[0].right = in_right;

  for (genvar i = 0; i < STAGES; i++) begin : g_cell
    tea_cell #(
      .STEP   (i),
      .ROUNDS (ROUNDS)
    ) u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .en        (en),
      .in_valid  (stage_valid[i]),
      .in_blk    (stage_blk[i]),
      .key       (key_r),
      .out_valid (stage_valid[i+1]),
      .out_blk   (stage_blk[i+1])
    );
  end

  tea_obuf u_obuf (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (stage_valid[STAGES]),
    .in_blk    (stage_blk[STAGES]),
    .full      (buf_full),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_blk   (res_blk)
  );

  assign out_left  = res_blk.left;
  assign out_right = res_blk.right;

`ifndef ASSERT_OFF
  a_stall_only_on_full_output: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid)
    else $error("input stalled with no result waiting");

  a_key_write_lands: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_valid && cfg_index == tea_pkg::KEY_W0_IDX |=> key_r.w0 == $past(cfg_data))
    else $error("key word 0 write was lost");

  a_last_cell_drains: assert property (@(posedge clk) disable iff (!rst_n)
    stage_valid[STAGES] && !in_stall |=> out_valid || in_stall)
    else $error("block leaving the chain was dropped");
`endif

endmodule
